// ===== design/bph_pkg.sv =====
// Shared types and constants for the button press/hold event detector.
package bph_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned DUR_W     = 23;
	localparam int unsigned READ_W    = 16;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned PROD_W    = 2 * TIME_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_INTERVAL = CFG_IDX_W'(1);

	localparam logic [TIME_W-1:0] HOLD_RESET_US = TIME_W'(500000);
	localparam logic [READ_W-1:0] FULL_READING  = 16'hFFFF;

	// x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
	localparam logic [TIME_W-1:0] DIV_MAGIC = 32'h10624DD3;
	localparam int unsigned       DIV_SHIFT = 38;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_DOWN = 2'd1,
		EV_UP   = 2'd2,
		EV_HOLD = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic                   we;
		logic [CFG_IDX_W-1:0]   index;
		logic [TIME_W-1:0]      data;
	} cfg_wr_t;

	typedef struct packed {
		ev_kind_t               kind;
		logic                   pressed;
		logic [TIME_W-1:0]      elapsed;
	} ev_t;

endpackage

// ===== design/bph_track.sv =====
// Press state tracking, configuration registers and event decision.
module bph_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bph_pkg::cfg_wr_t            cfg,
	input  logic                        step,
	input  logic                        pin_level,
	input  logic [bph_pkg::TIME_W-1:0]  now_us,
	output bph_pkg::ev_t                ev
);

	logic                       active_level_q;
	logic [bph_pkg::TIME_W-1:0] hold_interval_q;
	logic                       last_pressed_q;
	logic [bph_pkg::TIME_W-1:0] press_start_q;
	logic [bph_pkg::TIME_W-1:0] next_hold_q;

	logic                       pressed;
	logic [bph_pkg::TIME_W-1:0] elapsed;

	assign pressed = (pin_level == active_level_q);
	assign elapsed = now_us - press_start_q;

	always_comb begin
		ev.pressed = pressed;
		ev.kind    = bph_pkg::EV_NONE;
		ev.elapsed = '0;
		if (pressed != last_pressed_q) begin
			if (pressed) begin
				ev.kind = bph_pkg::EV_DOWN;
			end else begin
				ev.kind    = bph_pkg::EV_UP;
				ev.elapsed = elapsed;
			end
		end else if (pressed && (elapsed >= next_hold_q)) begin
			ev.kind    = bph_pkg::EV_HOLD;
			ev.elapsed = elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q  <= 1'b0;
			hold_interval_q <= bph_pkg::HOLD_RESET_US;
			last_pressed_q  <= 1'b0;
			press_start_q   <= '0;
			next_hold_q     <= '0;
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					bph_pkg::REG_ACTIVE_LEVEL:  active_level_q  <= cfg.data[0];
					bph_pkg::REG_HOLD_INTERVAL: hold_interval_q <= cfg.data;
					default: ;
				endcase
			end
			if (step) begin
				last_pressed_q <= pressed;
				case (ev.kind)
					bph_pkg::EV_DOWN: begin
						press_start_q <= now_us;
						next_hold_q   <= hold_interval_q;
					end
					bph_pkg::EV_HOLD: next_hold_q <= next_hold_q + hold_interval_q;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== design/bph_ms_div.sv =====
// Microsecond-to-millisecond conversion pipeline and result register.
module bph_ms_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ev_valid,
	input  bph_pkg::ev_t                ev,
	output logic                        ev_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  event_kind,
	output logic [bph_pkg::DUR_W-1:0]   duration_ms,
	output logic                        is_pressed,
	output logic [bph_pkg::READ_W-1:0]  reading
);

	logic                       valid_s2;
	bph_pkg::ev_t               ev_s2;
	logic                       valid_s3;
	bph_pkg::ev_kind_t          kind_s3;
	logic                       pressed_s3;
	logic [bph_pkg::PROD_W-1:0] prod_s3;

	logic ready_s2;
	logic ready_s3;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ev_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= ev_valid;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && ev_valid) ev_s2 <= ev;
		if (ready_s3 && valid_s2) begin
			kind_s3    <= ev_s2.kind;
			pressed_s3 <= ev_s2.pressed;
			prod_s3    <= bph_pkg::PROD_W'(ev_s2.elapsed) *
			              bph_pkg::PROD_W'(bph_pkg::DIV_MAGIC);
		end
	end

	assign out_valid   = valid_s3;
	assign event_kind  = kind_s3;
	assign duration_ms = prod_s3[bph_pkg::DIV_SHIFT +: bph_pkg::DUR_W];
	assign is_pressed  = pressed_s3;
	assign reading     = pressed_s3 ? bph_pkg::FULL_READING : '0;

endmodule

// ===== design/button_press_hold_events.sv =====
// Top level of the button press/release/hold event detector.
// Pipeline: input register, event register, product register; the multiply
// by 1/1000 sets the depth. Throughput: one item per cycle while out_ready
// does not stall the result side; each item yields exactly one result item.
// Reset (arst_n low): press state and hold mark clear, active level 0,
// hold interval 500000 us, all pipeline stages empty.
module button_press_hold_events (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bph_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bph_pkg::TIME_W-1:0]      cfg_data,
	// sample channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            pin_level,
	input  logic [bph_pkg::TIME_W-1:0]      now_us,
	// event channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      event_kind,
	output logic [bph_pkg::DUR_W-1:0]       duration_ms,
	output logic                            is_pressed,
	output logic [bph_pkg::READ_W-1:0]      reading
);

	logic                       valid_s1;
	logic                       pin_level_s1;
	logic [bph_pkg::TIME_W-1:0] now_us_s1;

	logic             ev_ready;
	logic             step;
	bph_pkg::ev_t     ev;
	bph_pkg::cfg_wr_t cfg;

	// Configuration is always taken; the user must write only while the block is idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;
	assign cfg       = '{we: cfg_valid, index: cfg_index, data: cfg_data};

	// Advance the sample out of the input register when the event stage has room;
	// state updates only on that transfer so each sample is seen once.
	assign step     = valid_s1 && ev_ready;
	assign in_ready = !valid_s1 || ev_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the sample payload; no reset needed.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pin_level_s1 <= pin_level;
			now_us_s1    <= now_us;
		end
	end

	// Decide down/up/hold against the press state and update it.
	bph_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.pin_level (pin_level_s1),
		.now_us    (now_us_s1),
		.ev        (ev)
	);

	// Convert elapsed microseconds to milliseconds and drive the result item.
	bph_ms_div u_ms_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_valid    (valid_s1),
		.ev          (ev),
		.ev_ready    (ev_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_kind  (event_kind),
		.duration_ms (duration_ms),
		.is_pressed  (is_pressed),
		.reading     (reading)
	);

endmodule

// ===== design/bph_checker.sv =====
// Port-level checker for the button event detector, bound to the top level.
module bph_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [1:0]                      event_kind,
	input logic [bph_pkg::DUR_W-1:0]       duration_ms,
	input logic                            is_pressed,
	input logic [bph_pkg::READ_W-1:0]      reading
);

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
		$stable(duration_ms) && $stable(is_pressed) && $stable(reading))
		else $error("result item changed while stalled");

	// Reading follows the pressed state.
	a_reading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_pressed ? (reading == bph_pkg::FULL_READING) : (reading == '0)))
		else $error("reading does not match pressed state");

	// Only up and hold carry a duration.
	a_dur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == bph_pkg::EV_NONE || event_kind == bph_pkg::EV_DOWN)
		|-> duration_ms == '0)
		else $error("duration on an event without one");

	// Down and hold happen while pressed, up while released.
	a_kind_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == bph_pkg::EV_DOWN && is_pressed) ||
		(event_kind == bph_pkg::EV_HOLD && is_pressed) ||
		(event_kind == bph_pkg::EV_UP && !is_pressed) ||
		(event_kind == bph_pkg::EV_NONE)))
		else $error("event kind disagrees with pressed state");

endmodule

bind button_press_hold_events bph_checker u_bph_checker (.*);
